// ----- rtl/jscf_pkg.sv -----
// ----------------------------------------------------------------------------
// jscf_pkg
// Types, constants and lookup functions shared by the JSON colour formatter.
// ----------------------------------------------------------------------------
package jscf_pkg;

    // Fixed field widths
    localparam int CHAR_W   = 8;
    localparam int COLOUR_W = 3;
    localparam int INDENT_W = 5;
    localparam int KIND_W   = 2;

    // Plan queue depth (power of two)
    localparam int QUEUE_DEPTH = 4;

    // Symbol classes
    typedef enum logic [3:0] {
        SYM_DIGIT  = 4'd0,
        SYM_ALPHA  = 4'd1,
        SYM_QUOTE  = 4'd2,
        SYM_BSLASH = 4'd3,
        SYM_LBRACE = 4'd4,
        SYM_RBRACE = 4'd5,
        SYM_LBRACK = 4'd6,
        SYM_RBRACK = 4'd7,
        SYM_COMMA  = 4'd8,
        SYM_COLON  = 4'd9,
        SYM_DOT    = 4'd10,
        SYM_SPACE  = 4'd11,
        SYM_SIGN   = 4'd12,
        SYM_OTHER  = 4'd13
    } sym_t;

    // Lexer states
    typedef enum logic [3:0] {
        ST_AWAIT            = 4'd0,
        ST_IN_NAME_STRING   = 4'd1,
        ST_NAME_STRING_ESC  = 4'd2,
        ST_NAME_END         = 4'd3,
        ST_AWAIT_VALUE      = 4'd4,
        ST_IN_VALUE_STRING  = 4'd5,
        ST_VALUE_STRING_ESC = 4'd6,
        ST_VALUE_STRING_END = 4'd7,
        ST_CONSUME_NUMERIC  = 4'd8,
        ST_CONSUME_FLOAT    = 4'd9,
        ST_CONSUME_BOOL     = 4'd10
    } lex_state_t;

    // Transition table marker for an illegal move
    localparam logic [3:0] NEXT_ILLEGAL = 4'd11;

    // Token kinds
    typedef enum logic [1:0] {
        TOK_LIT    = 2'd0,
        TOK_COLOUR = 2'd1,
        TOK_ALARM  = 2'd2,
        TOK_BREAK  = 2'd3
    } tok_kind_t;

    // Token slots of one byte, in emission order
    localparam int SLOT_ALARM  = 0;
    localparam int SLOT_PRE    = 1;
    localparam int SLOT_COLOUR = 2;
    localparam int SLOT_LIT    = 3;
    localparam int SLOT_POST   = 4;
    localparam int NUM_SLOTS   = 5;

    // Characters
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;

    // Colour codes
    localparam logic [COLOUR_W-1:0] COL_WHITE   = 3'd0;
    localparam logic [COLOUR_W-1:0] COL_BLUE    = 3'd1;
    localparam logic [COLOUR_W-1:0] COL_GREEN   = 3'd2;
    localparam logic [COLOUR_W-1:0] COL_CYAN    = 3'd3;
    localparam logic [COLOUR_W-1:0] COL_RED     = 3'd4;
    localparam logic [COLOUR_W-1:0] COL_MAGENTA = 3'd5;

    // Work plan for one byte, handed from front to back
    typedef struct packed {
        logic [NUM_SLOTS-1:0] slots;
        logic [CHAR_W-1:0]    char_val;
        logic [COLOUR_W-1:0]  colour;
        logic [INDENT_W-1:0]  indent;
        logic                 post_space;
    } plan_t;

    // Transition table, rows by state, columns by symbol class
    localparam logic [3:0] NEXT_TAB [11][14] = '{
        '{4'd8, 4'd10, 4'd1, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd11,
          4'd11, 4'd0, 4'd8, 4'd11},
        '{4'd1, 4'd1, 4'd3, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
          4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
          4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd4,
          4'd11, 4'd3, 4'd11, 4'd11},
        '{4'd8, 4'd10, 4'd5, 4'd11, 4'd0, 4'd11, 4'd0, 4'd11, 4'd11, 4'd11,
          4'd11, 4'd4, 4'd8, 4'd11},
        '{4'd5, 4'd5, 4'd7, 4'd6, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5,
          4'd5, 4'd5, 4'd5, 4'd5},
        '{4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5,
          4'd5, 4'd5, 4'd5, 4'd5},
        '{4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd0, 4'd11, 4'd11, 4'd0, 4'd11,
          4'd11, 4'd0, 4'd11, 4'd11},
        '{4'd8, 4'd11, 4'd11, 4'd11, 4'd11, 4'd0, 4'd11, 4'd0, 4'd0, 4'd11,
          4'd9, 4'd0, 4'd11, 4'd11},
        '{4'd9, 4'd11, 4'd11, 4'd11, 4'd11, 4'd0, 4'd11, 4'd0, 4'd0, 4'd11,
          4'd11, 4'd0, 4'd11, 4'd11},
        '{4'd11, 4'd10, 4'd11, 4'd11, 4'd11, 4'd0, 4'd11, 4'd0, 4'd0, 4'd11,
          4'd11, 4'd0, 4'd11, 4'd11}
    };

    // Sort a byte into its symbol class
    function automatic sym_t classify(input logic [CHAR_W-1:0] c);
        sym_t s;
        if ((c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z)) begin
            s = SYM_ALPHA;
        end
        else if (c >= CH_ZERO && c <= CH_NINE) begin
            s = SYM_DIGIT;
        end
        else begin
            case (c)
                CH_TAB, CH_LF, CH_SPACE: s = SYM_SPACE;
                CH_MINUS, CH_PLUS:       s = SYM_SIGN;
                CH_DOT:                  s = SYM_DOT;
                CH_COLON:                s = SYM_COLON;
                CH_QUOTE:                s = SYM_QUOTE;
                CH_BSLASH:               s = SYM_BSLASH;
                CH_RBRACK:               s = SYM_RBRACK;
                CH_LBRACK:               s = SYM_LBRACK;
                CH_RBRACE:               s = SYM_RBRACE;
                CH_LBRACE:               s = SYM_LBRACE;
                CH_COMMA:                s = SYM_COMMA;
                default:                 s = SYM_OTHER;
            endcase
        end
        return s;
    endfunction

    // Table lookup; unused state codes behave as Await
    function automatic logic [3:0] next_code(input lex_state_t s, input sym_t y);
        lex_state_t row;
        row = (s > ST_CONSUME_BOOL) ? ST_AWAIT : s;
        return NEXT_TAB[row][y];
    endfunction

    // Colour shown in each state
    function automatic logic [COLOUR_W-1:0] colour_of(input lex_state_t s);
        logic [COLOUR_W-1:0] c;
        case (s)
            ST_AWAIT:            c = COL_WHITE;
            ST_IN_NAME_STRING:   c = COL_BLUE;
            ST_NAME_STRING_ESC:  c = COL_RED;
            ST_NAME_END:         c = COL_BLUE;
            ST_AWAIT_VALUE:      c = COL_WHITE;
            ST_IN_VALUE_STRING:  c = COL_CYAN;
            ST_VALUE_STRING_ESC: c = COL_RED;
            ST_VALUE_STRING_END: c = COL_CYAN;
            ST_CONSUME_NUMERIC:  c = COL_GREEN;
            ST_CONSUME_FLOAT:    c = COL_GREEN;
            ST_CONSUME_BOOL:     c = COL_MAGENTA;
            default:             c = COL_WHITE;
        endcase
        return c;
    endfunction

    // String and escape states suppress formatting
    function automatic logic in_string(input lex_state_t s);
        return (s == ST_IN_NAME_STRING) || (s == ST_NAME_STRING_ESC) ||
               (s == ST_IN_VALUE_STRING) || (s == ST_VALUE_STRING_ESC);
    endfunction

endpackage

// ----- rtl/jscf_if.sv -----
// ----------------------------------------------------------------------------
// jscf_if
// Valid/ready stream interfaces for the character input and token output.
// ----------------------------------------------------------------------------

// Character stream: one byte of JSON text per transfer
interface jscf_char_if;
    logic                          valid;
    logic                          ready;
    logic [jscf_pkg::CHAR_W-1:0]   char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

// Token stream: one formatted token per transfer
interface jscf_token_if;
    logic                          valid;
    logic                          ready;
    logic [jscf_pkg::KIND_W-1:0]   token_kind;
    logic [jscf_pkg::CHAR_W-1:0]   byte_out;
    logic [jscf_pkg::COLOUR_W-1:0] colour_code;
    logic [jscf_pkg::INDENT_W-1:0] indent_level;
    logic                          last_of_run;

    modport source (output valid, output token_kind, output byte_out, output colour_code,
                    output indent_level, output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input byte_out, input colour_code,
                    input indent_level, input last_of_run, output ready);
endinterface

// ----- rtl/jscf_front.sv -----
// ----------------------------------------------------------------------------
// jscf_front
// Accepts bytes, classifies them, steps the lexer and nesting depth, and
// builds the token plan for each byte.
// ----------------------------------------------------------------------------
module jscf_front #(
    parameter int MAX_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    jscf_char_if.sink          char_chan,
    input  logic               queue_full,
    output logic               push,
    output jscf_pkg::plan_t    push_plan
);

    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam int INDENT_W = jscf_pkg::INDENT_W;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);
    localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);

    logic                    pretty_reg;
    jscf_pkg::lex_state_t    lex_state_reg, lex_state_next;
    logic [DEPTH_W-1:0]      depth_reg, depth_next;

    jscf_pkg::sym_t          sym;
    logic [3:0]              code;
    logic                    illegal;
    logic                    fmt;
    logic                    closer, opener;

    // Handshake
    assign char_chan.ready = !queue_full;
    assign push            = char_chan.valid && !queue_full;

    // Classification and lexer step
    always_comb
    begin
        sym     = jscf_pkg::classify(char_chan.char_in);
        code    = jscf_pkg::next_code(lex_state_reg, sym);
        illegal = (code == jscf_pkg::NEXT_ILLEGAL);
        lex_state_next = illegal ? lex_state_reg : jscf_pkg::lex_state_t'(code);
        fmt     = pretty_reg && !jscf_pkg::in_string(lex_state_reg);
        closer  = (sym == jscf_pkg::SYM_RBRACE) || (sym == jscf_pkg::SYM_RBRACK);
        opener  = (sym == jscf_pkg::SYM_LBRACE) || (sym == jscf_pkg::SYM_LBRACK);
    end

    // Saturating depth update
    always_comb
    begin
        depth_next = depth_reg;
        if (fmt && closer && depth_reg != '0)
        begin
            depth_next = depth_reg - DEPTH_ONE;
        end
        else if (fmt && opener && depth_reg != DEPTH_MAX)
        begin
            depth_next = depth_reg + DEPTH_ONE;
        end
    end

    // Token plan
    always_comb
    begin
        push_plan = '0;
        push_plan.slots[jscf_pkg::SLOT_ALARM]  = illegal;
        push_plan.slots[jscf_pkg::SLOT_PRE]    = fmt && closer;
        push_plan.slots[jscf_pkg::SLOT_COLOUR] = (lex_state_next != lex_state_reg);
        push_plan.slots[jscf_pkg::SLOT_LIT]    = 1'b1;
        push_plan.slots[jscf_pkg::SLOT_POST]   =
            fmt && (opener || sym == jscf_pkg::SYM_COMMA || sym == jscf_pkg::SYM_COLON);
        push_plan.char_val   = char_chan.char_in;
        push_plan.colour     = jscf_pkg::colour_of(lex_state_next);
        push_plan.indent     = INDENT_W'(depth_next);
        push_plan.post_space = (sym == jscf_pkg::SYM_COLON);
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pretty_reg    <= 1'b1;
            lex_state_reg <= jscf_pkg::ST_AWAIT;
            depth_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                pretty_reg <= cfg_wr_data;
            end
            if (push)
            begin
                lex_state_reg <= lex_state_next;
                depth_reg     <= depth_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_MAX)
        else $error("nesting depth above limit");

    a_string_no_fmt: assert property (@(posedge clk) disable iff (!rst_n)
        push && jscf_pkg::in_string(lex_state_reg) |=> $stable(depth_reg))
        else $error("depth changed inside a string");
`endif

endmodule

// ----- rtl/jscf_queue.sv -----
// ----------------------------------------------------------------------------
// jscf_queue
// Short FIFO of token plans between the front and back ends.
// ----------------------------------------------------------------------------
module jscf_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  jscf_pkg::plan_t    push_plan,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output jscf_pkg::plan_t    head_plan
);

    localparam int DEPTH = jscf_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam logic [PTR_W-1:0] PTR_ONE = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

    jscf_pkg::plan_t     entries_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg, count_next;

    assign full       = (count_reg == CNT_MAX);
    assign head_valid = (count_reg != '0);
    assign head_plan  = entries_reg[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_ONE;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_ONE;
        end
    end

    // Pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_ONE;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_ONE;
            end
            count_reg <= count_next;
        end
    end

    // Plan storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_plan;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("plan pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !head_valid))
        else $error("plan popped from empty queue");
`endif

endmodule

// ----- rtl/jscf_back.sv -----
// ----------------------------------------------------------------------------
// jscf_back
// Walks each token plan one slot at a time and drives the registered
// token output.
// ----------------------------------------------------------------------------
module jscf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  jscf_pkg::plan_t    head_plan,
    output logic               pop,
    jscf_token_if.source       token_chan
);

    localparam int NS = jscf_pkg::NUM_SLOTS;
    localparam logic [NS-1:0] SLOT_ONE = NS'(1);

    // Plan being worked on; slots still to send
    jscf_pkg::plan_t          cur_plan_reg;
    logic [NS-1:0]            cur_slots_reg, cur_slots_next;

    // Output register
    logic                          tok_valid_reg, tok_valid_next;
    jscf_pkg::tok_kind_t           tok_kind_reg, tok_kind_next;
    logic [jscf_pkg::CHAR_W-1:0]   tok_byte_reg, tok_byte_next;
    logic [jscf_pkg::COLOUR_W-1:0] tok_colour_reg, tok_colour_next;
    logic [jscf_pkg::INDENT_W-1:0] tok_indent_reg, tok_indent_next;
    logic                          tok_last_reg, tok_last_next;

    logic                     have_cur;
    jscf_pkg::plan_t          src_plan;
    logic [NS-1:0]            src_slots;
    logic                     src_ok;
    logic                     advance;
    logic                     load;
    logic [NS-1:0]            sel;
    logic [NS-1:0]            rest;

    // Source selection and slot pick
    always_comb
    begin
        have_cur  = (cur_slots_reg != '0);
        src_plan  = have_cur ? cur_plan_reg : head_plan;
        src_slots = have_cur ? cur_slots_reg : head_plan.slots;
        src_ok    = have_cur || head_valid;
        advance   = !tok_valid_reg || token_chan.ready;
        load      = advance && src_ok;
        pop       = load && !have_cur;
        sel       = src_slots & (~src_slots + SLOT_ONE);
        rest      = src_slots & ~sel;
        cur_slots_next = load ? rest : cur_slots_reg;
        tok_valid_next = load ? 1'b1 : (advance ? 1'b0 : tok_valid_reg);
    end

    // Token fields for the picked slot
    always_comb
    begin
        tok_kind_next   = jscf_pkg::TOK_LIT;
        tok_byte_next   = '0;
        tok_colour_next = '0;
        tok_indent_next = '0;
        tok_last_next   = (rest == '0);
        if (sel[jscf_pkg::SLOT_ALARM])
        begin
            tok_kind_next = jscf_pkg::TOK_ALARM;
        end
        else if (sel[jscf_pkg::SLOT_PRE])
        begin
            tok_kind_next   = jscf_pkg::TOK_BREAK;
            tok_indent_next = src_plan.indent;
        end
        else if (sel[jscf_pkg::SLOT_COLOUR])
        begin
            tok_kind_next   = jscf_pkg::TOK_COLOUR;
            tok_colour_next = src_plan.colour;
        end
        else if (sel[jscf_pkg::SLOT_LIT])
        begin
            tok_byte_next = src_plan.char_val;
        end
        else if (src_plan.post_space)
        begin
            tok_byte_next = jscf_pkg::CH_SPACE;
        end
        else
        begin
            tok_kind_next   = jscf_pkg::TOK_BREAK;
            tok_indent_next = src_plan.indent;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_slots_reg <= '0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            cur_slots_reg <= cur_slots_next;
            tok_valid_reg <= tok_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_plan_reg <= head_plan;
        end
        if (load)
        begin
            tok_kind_reg   <= tok_kind_next;
            tok_byte_reg   <= tok_byte_next;
            tok_colour_reg <= tok_colour_next;
            tok_indent_reg <= tok_indent_next;
            tok_last_reg   <= tok_last_next;
        end
    end

    assign token_chan.valid        = tok_valid_reg;
    assign token_chan.token_kind   = tok_kind_reg;
    assign token_chan.byte_out     = tok_byte_reg;
    assign token_chan.colour_code  = tok_colour_reg;
    assign token_chan.indent_level = tok_indent_reg;
    assign token_chan.last_of_run  = tok_last_reg;

`ifndef SYNTHESIS
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        load && tok_last_next |=> cur_slots_reg == '0)
        else $error("slots left after last token of a byte");

    a_no_pop_midway: assert property (@(posedge clk) disable iff (!rst_n)
        cur_slots_reg != '0 |-> !pop)
        else $error("new plan taken while one is still in progress");
`endif

endmodule

// ----- rtl/json_stream_colour_formatter.sv -----
// ----------------------------------------------------------------------------
// json_stream_colour_formatter
// Lexes a JSON byte stream and emits colour, alarm, literal and line-break
// tokens for a terminal pretty printer.
// ----------------------------------------------------------------------------
// Usage:
//   char_chan takes one JSON byte per transfer; token_chan gives one token per
//   transfer, with last_of_run set on the final token of each byte.
//   cfg_wr_en/cfg_wr_data write pretty_enable (reset 1); write it only idle.
// Path: a byte's plan is written into the plan queue when the byte transfers;
//   the back end then loads its first token into the output register, given
//   an empty pipeline and a ready receiver.
// Throughput: one token per cycle while the receiver is ready, set by the
//   single output register; a byte gives 1 to 3 tokens on the token side.
//   The front takes a byte every cycle while the four-entry plan queue has
//   room, so short and long bytes even out.
// Reset: lexer back to Await, nesting depth 0, queue and output emptied.
// Stall: when the receiver holds token_chan.ready low the token stays put,
//   the queue fills, and char_chan.ready drops once four plans wait.
// ----------------------------------------------------------------------------
module json_stream_colour_formatter #(
    parameter int MAX_DEPTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  logic           cfg_wr_data,
    jscf_char_if.sink      char_chan,
    jscf_token_if.source   token_chan
);

    logic               push;
    logic               pop;
    logic               queue_full;
    logic               head_valid;
    jscf_pkg::plan_t    push_plan;
    jscf_pkg::plan_t    head_plan;

    // Front end: classify and plan
    jscf_front #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .char_chan   (char_chan),
        .queue_full  (queue_full),
        .push        (push),
        .push_plan   (push_plan)
    );

    // Plan queue
    jscf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_plan  (push_plan),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_plan  (head_plan)
    );

    // Back end: emit tokens
    jscf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_plan  (head_plan),
        .pop        (pop),
        .token_chan (token_chan)
    );

endmodule
